// File: rtl/first_fit_block_allocator_macros.svh
// assertion macros for the first-fit block allocator
// no dependencies; the assertion bodies are left out when SYNTH is defined
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

`define FFBA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FFBA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FFBA_ASSERT(lbl, clk, rst_n, prop, msg)

`define FFBA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/ffba_pkg.sv
// shared types and codes of the first-fit block allocator
// no dependencies
package ffba_pkg;

	// byte offsets inside the walk stay below 2^19 (17-bit limit plus one header)
	localparam int OFF_W = 19;
	localparam int HDR_W = 18;
	localparam int ALU_W = 21;
	localparam int CFG_W = 17;

	typedef logic [OFF_W-1:0] off_t;
	typedef logic signed [HDR_W-1:0] hdr_t;
	typedef logic signed [ALU_W-1:0] alu_t;

	localparam logic [1:0] FUNC_INIT  = 2'd0;
	localparam logic [1:0] FUNC_ALLOC = 2'd1;
	localparam logic [1:0] FUNC_FREE  = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_TOO_BIG   = 2'd1;
	localparam logic [1:0] STAT_NO_FIT    = 2'd2;
	localparam logic [1:0] STAT_NOT_READY = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [16:0] request_bytes;
		logic [15:0] block_offset;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] payload_offset;
	} rsp_t;

endpackage

// File: rtl/ffba_word_div.sv
// byte offset to header word index, with a store range flag
// depends on ffba_pkg; division by the word size is a reciprocal multiply
module ffba_word_div import ffba_pkg::*; #(
	parameter int POOL_WORDS = 8192,
	parameter int WORD_BYTES = 8,
	parameter int ADDR_W     = 13
) (
	input  off_t              dividend,
	output off_t              quot,
	output logic              in_store,
	output logic [ADDR_W-1:0] addr
);

	localparam int L       = $clog2(WORD_BYTES);
	localparam int SHIFT   = OFF_W + L;
	localparam int RECIP_W = OFF_W + 1;
	localparam int PROD_W  = OFF_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(WORD_BYTES - 1)) / 64'(WORD_BYTES));

	logic [PROD_W-1:0] prod;

	// exact for every dividend below 2^OFF_W
	assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
	assign quot     = OFF_W'(prod[PROD_W-1:SHIFT]);
	assign in_store = 32'(quot) < 32'(POOL_WORDS);
	assign addr     = ADDR_W'(quot);

endmodule

// File: rtl/first_fit_block_allocator.sv
// top level of the first-fit block allocator: sequencer, shared adder, header memory
// depends on ffba_pkg, ffba_word_div and first_fit_block_allocator_macros.svh
//
// usage:
// a command word (func, request_bytes, block_offset) is taken at a clock edge where
// start is high and busy is low. busy stays high until the result word (status,
// payload_offset) is shown for exactly one cycle with done high; the next command
// may start in that same cycle. the receiver cannot stall and must take done words
// as they come.
// cfg_we writes pool_bytes, which init uses; write it only while busy is low.
// every command passes S_PREP; init goes on to S_INIT, free to S_FREE_WR (unless the
// offset is ignored), while a nop or an allocate refused before the walk ends there.
// a walking allocate goes on to S_NEED, then S_OUTER and S_HDR per header visited,
// S_NXT_RD and S_NXT to read the neighbor of a free block that does not fit, S_MERGE,
// S_NXT_RD and S_NXT per merge of a free neighbor, S_TAKE to take the chosen block
// whole or S_SPLIT0-2 to split it, so its run grows with the pool's fragmentation.
// all header accesses go through the one memory port; some sums bypass the shared adder.
// after reset the pool is not initialised (allocate gives status 3), pool_bytes
// is 65536 and the header memory holds no defined contents; there is no clearing
// pass, init lays out the only header it needs.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int POOL_WORDS = 8192,
	parameter int WORD_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cmd_t             cmd,
	output logic             busy,
	output logic             done,
	output rsp_t             result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int ADDR_W  = $clog2(POOL_WORDS);
	localparam int GUARD_W = $clog2(4 * POOL_WORDS + 17);
	localparam logic [GUARD_W-1:0] GUARD_INIT = GUARD_W'(4 * POOL_WORDS + 16);
	localparam int unsigned CAP = POOL_WORDS * WORD_BYTES;
	localparam alu_t W_A     = alu_t'(WORD_BYTES);
	localparam alu_t TWO_W_A = alu_t'(2 * WORD_BYTES);
	localparam off_t W_O     = OFF_W'(WORD_BYTES);

	typedef enum logic [13:0] {
		S_IDLE    = 14'h0001,
		S_PREP    = 14'h0002,
		S_INIT    = 14'h0004,
		S_NEED    = 14'h0008,
		S_OUTER   = 14'h0010,
		S_HDR     = 14'h0020,
		S_NXT_RD  = 14'h0040,
		S_NXT     = 14'h0080,
		S_MERGE   = 14'h0100,
		S_SPLIT0  = 14'h0200,
		S_SPLIT1  = 14'h0400,
		S_SPLIT2  = 14'h0800,
		S_TAKE    = 14'h1000,
		S_FREE_WR = 14'h2000
	} state_t;

	state_t state_q, state_d;
	logic done_q, done_d;
	logic ready_q, ready_d;
	logic [CFG_W-1:0] lim_q, lim_d;
	logic [CFG_W-1:0] pool_bytes_q, pool_bytes_d;

	cmd_t cmd_q, cmd_d;
	rsp_t result_q, result_d;
	off_t prep_q, prep_d;
	off_t q_q, q_d;
	off_t search_q, search_d;
	off_t nxt_q, nxt_d;
	off_t split_q, split_d;
	off_t needw_q, needw_d;
	logic [HDR_W-1:0] need_q, need_d;
	hdr_t cur_h_q, cur_h_d;
	logic [GUARD_W-1:0] guard_q, guard_d;
	logic merged_q, merged_d;

	hdr_t hdr_mem [POOL_WORDS];
	hdr_t mem_rdata_q;
	logic mem_re, mem_we;
	hdr_t mem_wdata;
	logic [ADDR_W-1:0] mem_addr;

	off_t div_in, div_q;
	logic div_ok;
	logic [ADDR_W-1:0] div_addr;

	alu_t alu_a, alu_b, alu_y;
	alu_t hx, curx, needx, needwx, limx, searchx, nxtx;
	off_t qw, sz;

	logic fin;
	logic [1:0] fin_status;
	logic [15:0] fin_offset;

	ffba_word_div #(
		.POOL_WORDS(POOL_WORDS),
		.WORD_BYTES(WORD_BYTES),
		.ADDR_W    (ADDR_W)
	) u_div (
		.dividend(div_in),
		.quot    (div_q),
		.in_store(div_ok),
		.addr    (div_addr)
	);

	assign hx      = alu_t'(mem_rdata_q);
	assign curx    = alu_t'(cur_h_q);
	assign needx   = alu_t'(need_q);
	assign needwx  = alu_t'(needw_q);
	assign limx    = alu_t'(lim_q);
	assign searchx = alu_t'(search_q);
	assign nxtx    = alu_t'(nxt_q);
	assign alu_y   = alu_a + alu_b;

	// q_q * word size never exceeds the dividend, so it fits an offset
	assign qw = OFF_W'(q_q * W_O);
	assign sz = (32'(qw) > CAP) ? OFF_W'(CAP) : qw;

	always_comb begin
		case (state_q)
			S_PREP, S_FREE_WR: div_in = prep_q;
			S_NXT_RD:          div_in = nxt_q;
			S_SPLIT1:          div_in = split_q;
			default:           div_in = search_q;
		endcase
	end

	assign mem_addr = (state_q == S_INIT) ? ADDR_W'(1) : div_addr;

	always_comb begin
		state_d      = state_q;
		done_d       = 1'b0;
		ready_d      = ready_q;
		lim_d        = lim_q;
		pool_bytes_d = pool_bytes_q;
		cmd_d        = cmd_q;
		result_d     = result_q;
		prep_d       = prep_q;
		q_d          = q_q;
		search_d     = search_q;
		nxt_d        = nxt_q;
		split_d      = split_q;
		needw_d      = needw_q;
		need_d       = need_q;
		cur_h_d      = cur_h_q;
		guard_d      = guard_q;
		merged_d     = merged_q;
		mem_re       = 1'b0;
		mem_we       = 1'b0;
		mem_wdata    = cur_h_q;
		alu_a        = '0;
		alu_b        = '0;
		fin          = 1'b0;
		fin_status   = STAT_OK;
		fin_offset   = '0;

		case (state_q)
			S_IDLE: begin
				case (cmd.func)
					FUNC_INIT: begin
						alu_a = alu_t'(pool_bytes_q);
					end
					FUNC_ALLOC: begin
						alu_a = alu_t'(cmd.request_bytes);
						alu_b = W_A - alu_t'(1);
					end
					FUNC_FREE: begin
						alu_a = alu_t'(cmd.block_offset);
						alu_b = -W_A;
					end
					default: begin
						alu_a = '0;
					end
				endcase
				if (start) begin
					cmd_d   = cmd;
					prep_d  = OFF_W'(alu_y);
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				q_d = div_q;
				case (cmd_q.func)
					FUNC_INIT: begin
						state_d = S_INIT;
					end
					FUNC_ALLOC: begin
						if (!ready_q) begin
							fin        = 1'b1;
							fin_status = STAT_NOT_READY;
						end else if (cmd_q.request_bytes == '0) begin
							fin        = 1'b1;
							fin_status = STAT_NO_FIT;
						end else if (alu_t'(cmd_q.request_bytes) > limx - TWO_W_A) begin
							fin        = 1'b1;
							fin_status = STAT_TOO_BIG;
						end else begin
							state_d = S_NEED;
						end
					end
					FUNC_FREE: begin
						if (alu_t'(cmd_q.block_offset) < TWO_W_A || !div_ok) begin
							fin = 1'b1;
						end else begin
							mem_re  = 1'b1;
							state_d = S_FREE_WR;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_INIT: begin
				fin = 1'b1;
				if (alu_t'(sz) < TWO_W_A) begin
					ready_d    = 1'b0;
					fin_status = STAT_NOT_READY;
				end else begin
					ready_d   = 1'b1;
					lim_d     = CFG_W'(sz);
					mem_we    = 1'b1;
					mem_wdata = HDR_W'(sz - W_O);
				end
			end
			S_NEED: begin
				need_d   = HDR_W'(qw);
				needw_d  = qw + W_O;
				search_d = W_O;
				guard_d  = GUARD_INIT;
				state_d  = S_OUTER;
			end
			S_OUTER: begin
				if (searchx < limx && guard_q != '0) begin
					guard_d = guard_q - GUARD_W'(1);
					mem_re  = 1'b1;
					state_d = S_HDR;
				end else begin
					fin        = 1'b1;
					fin_status = STAT_NO_FIT;
				end
			end
			S_HDR: begin
				// one add serves both the jump over a used block and the next header
				alu_a    = searchx;
				alu_b    = (mem_rdata_q < 0) ? -hx : hx;
				cur_h_d  = mem_rdata_q;
				merged_d = 1'b0;
				if (mem_rdata_q == '0) begin
					fin        = 1'b1;
					fin_status = STAT_NO_FIT;
				end else if (needx <= hx - W_A) begin
					state_d = (needx <= hx - TWO_W_A) ? S_SPLIT0 : S_TAKE;
				end else if (mem_rdata_q < 0) begin
					search_d = OFF_W'(alu_y);
					state_d  = S_OUTER;
				end else if (alu_y >= limx) begin
					fin        = 1'b1;
					fin_status = STAT_NO_FIT;
				end else begin
					nxt_d   = OFF_W'(alu_y);
					state_d = S_NXT_RD;
				end
			end
			S_NXT_RD: begin
				mem_re  = 1'b1;
				state_d = S_NXT;
			end
			S_NXT: begin
				if (mem_rdata_q < 0 && !merged_q) begin
					// used neighbor: resume the walk past it
					alu_a    = nxtx;
					alu_b    = -hx;
					search_d = OFF_W'(alu_y);
					state_d  = S_OUTER;
				end else begin
					// after a merge a used neighbor ends the run, the merged block is retried
					alu_a = curx;
					alu_b = hx;
					if (mem_rdata_q > 0 && curx < needwx && guard_q != '0) begin
						guard_d = guard_q - GUARD_W'(1);
						cur_h_d = HDR_W'(alu_y);
						state_d = S_MERGE;
					end else begin
						state_d = S_OUTER;
					end
				end
			end
			S_MERGE: begin
				mem_we    = 1'b1;
				mem_wdata = cur_h_q;
				alu_a     = searchx;
				alu_b     = curx;
				merged_d  = 1'b1;
				if (alu_y >= 0 && alu_y < limx) begin
					nxt_d   = OFF_W'(alu_y);
					state_d = S_NXT_RD;
				end else begin
					state_d = S_OUTER;
				end
			end
			S_SPLIT0: begin
				alu_a   = searchx;
				alu_b   = needwx;
				split_d = OFF_W'(alu_y);
				state_d = S_SPLIT1;
			end
			S_SPLIT1: begin
				// header of the free remainder, dropped if it lands past the store
				alu_a     = curx;
				alu_b     = -needwx;
				mem_we    = div_ok;
				mem_wdata = HDR_W'(alu_y);
				state_d   = S_SPLIT2;
			end
			S_SPLIT2: begin
				mem_we     = 1'b1;
				mem_wdata  = HDR_W'(-needwx);
				fin        = 1'b1;
				fin_offset = 16'(search_q + W_O);
			end
			S_TAKE: begin
				mem_we     = 1'b1;
				mem_wdata  = -cur_h_q;
				fin        = 1'b1;
				fin_offset = 16'(search_q + W_O);
			end
			S_FREE_WR: begin
				mem_we    = div_ok;
				mem_wdata = -mem_rdata_q;
				fin       = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			state_d                 = S_IDLE;
			done_d                  = 1'b1;
			result_d.status         = fin_status;
			result_d.payload_offset = fin_offset;
		end

		if (cfg_we) begin
			pool_bytes_d = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			ready_q      <= 1'b0;
			lim_q        <= '0;
			pool_bytes_q <= 17'd65536;
		end else begin
			state_q      <= state_d;
			done_q       <= done_d;
			ready_q      <= ready_d;
			lim_q        <= lim_d;
			pool_bytes_q <= pool_bytes_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		result_q <= result_d;
		prep_q   <= prep_d;
		q_q      <= q_d;
		search_q <= search_d;
		nxt_q    <= nxt_d;
		split_q  <= split_d;
		needw_q  <= needw_d;
		need_q   <= need_d;
		cur_h_q  <= cur_h_d;
		guard_q  <= guard_d;
		merged_q <= merged_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hdr_mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= hdr_mem[mem_addr];
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`FFBA_ASSERT(a_done_when_idle, clk, arst_n, done |-> !busy, "done word while busy")
	`FFBA_ASSERT(a_start_goes_busy, clk, arst_n, (start && !busy) |=> busy, "word not started")
	`FFBA_ASSERT(a_finish_has_done, clk, arst_n, $fell(busy) |-> done, "ended without result")
	`FFBA_ASSERT(a_write_in_store, clk, arst_n, (mem_we && state_q != S_INIT) |-> div_ok, "bad write")
	`FFBA_ASSERT(a_ready_limit, clk, arst_n, ready_q |-> (lim_q >= 17'(2 * WORD_BYTES)), "small pool")
	`FFBA_ASSERT_NEVER(a_one_port_op, clk, arst_n, mem_we && mem_re, "read and write in one cycle")

endmodule

// File: test/first_fit_block_allocator_test.sv
// self-checking testbench for first_fit_block_allocator: directed table, then random alloc/free
// traffic checked against an in-bench model of the boundary-tag pool
// depends on ffba_pkg and the first_fit_block_allocator rtl
module first_fit_block_allocator_test;
	import ffba_pkg::*;

	localparam int POOL_WORDS = 8192;
	localparam int WORD_BYTES = 8;
	localparam int POOL_CAP = POOL_WORDS * WORD_BYTES;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int STALL_LIMIT = 600000;
	localparam int REPORT_MAX = 10;
	localparam int SEGMENT_WORDS = 64;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cmd_t word;
		int pool_value;
		bit typed;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t result;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// model of the pool: header words, which of them were ever written, config and limits
	int tag_mem [POOL_WORDS];
	bit tag_set [POOL_WORDS];
	int pool_bytes_reg = 65536;
	int arena_end = 0;
	bit arena_up = 1'b0;

	rsp_t expected_words [$];
	int live_blocks [$];
	plan_row_t directed_plan [$];

	int idle_pct = 0;
	int mismatches = 0;
	int stall_cycles = 0;
	int words_sent = 0;
	int results_seen = 0;
	int allocs_placed = 0;
	int allocs_refused = 0;
	int frees_sent = 0;
	int pool_writes = 0;

	first_fit_block_allocator #(
		.POOL_WORDS(POOL_WORDS),
		.WORD_BYTES(WORD_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int tag_at(int byte_off);
		int idx;
		idx = byte_off / WORD_BYTES;
		if (idx >= POOL_WORDS) return 0;
		return tag_mem[idx];
	endfunction

	function automatic void put_tag(int byte_off, int value);
		int idx;
		idx = byte_off / WORD_BYTES;
		if (idx < POOL_WORDS) begin
			tag_mem[idx] = value;
			tag_set[idx] = 1'b1;
		end
	endfunction

	// first-fit walk with lazy merging of free neighbors
	function automatic rsp_t carve_block(int req);
		rsp_t r;
		int lim, search, nxt, guard, need, h, hn;
		r = '0;
		lim = arena_end;
		guard = 4 * POOL_WORDS + 16;
		if (!arena_up) begin
			r.status = STAT_NOT_READY;
			return r;
		end
		if (req == 0) begin
			r.status = STAT_NO_FIT;
			return r;
		end
		if (req > lim - 2 * WORD_BYTES) begin
			r.status = STAT_TOO_BIG;
			return r;
		end
		need = ((req + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
		search = WORD_BYTES;
		while (search < lim && guard > 0) begin
			guard--;
			h = tag_at(search);
			if (h == 0) break;
			if (need <= h - WORD_BYTES) begin
				if (need <= h - 2 * WORD_BYTES) begin
					put_tag(search + WORD_BYTES + need, h - (need + WORD_BYTES));
					put_tag(search, -(need + WORD_BYTES));
				end else begin
					put_tag(search, -h);
				end
				r.payload_offset = 16'(search + WORD_BYTES);
				return r;
			end
			if (h < 0) begin
				search += -h;
			end else begin
				nxt = search + h;
				if (nxt >= lim) break;
				hn = tag_at(nxt);
				if (hn < 0) search = nxt - hn;
				while (nxt < lim && tag_at(nxt) > 0 && tag_at(search) < need + WORD_BYTES
						&& guard > 0) begin
					guard--;
					put_tag(search, tag_at(search) + tag_at(nxt));
					nxt = search + tag_at(search);
				end
			end
		end
		r.status = STAT_NO_FIT;
		return r;
	endfunction

	function automatic rsp_t predict_word(cmd_t w);
		rsp_t r;
		int sz, hb;
		r = '0;
		case (w.func)
			FUNC_INIT: begin
				sz = (pool_bytes_reg / WORD_BYTES) * WORD_BYTES;
				if (sz > POOL_CAP) sz = POOL_CAP;
				if (sz < 2 * WORD_BYTES) begin
					arena_up = 1'b0;
					r.status = STAT_NOT_READY;
				end else begin
					arena_end = sz;
					arena_up = 1'b1;
					put_tag(WORD_BYTES, sz - WORD_BYTES);
				end
			end
			FUNC_ALLOC: r = carve_block(int'(w.request_bytes));
			FUNC_FREE: begin
				// low offset bits drop out in the word index
				if (int'(w.block_offset) >= 2 * WORD_BYTES) begin
					hb = int'(w.block_offset) - WORD_BYTES;
					put_tag(hb, -tag_at(hb));
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_row(row_kind_t kind, logic [1:0] f, int req, int off, bit typed,
			logic [1:0] st, int po);
		plan_row_t row;
		row.kind = kind;
		row.word.func = f;
		row.word.request_bytes = 17'(req);
		row.word.block_offset = 16'(off);
		row.pool_value = req;
		row.typed = typed;
		row.want.status = st;
		row.want.payload_offset = 16'(po);
		directed_plan.push_back(row);
	endfunction

	task automatic send_word(cmd_t w, bit typed, rsp_t want);
		rsp_t pred;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		pred = predict_word(w);
		expected_words.push_back(typed ? want : pred);
		words_sent++;
		if (w.func == FUNC_FREE) frees_sent++;
		if (w.func == FUNC_ALLOC) begin
			if (pred.status == STAT_OK) begin
				allocs_placed++;
				live_blocks.push_back(int'(pred.payload_offset));
			end else begin
				allocs_refused++;
			end
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic write_pool(int value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_bytes_reg = value & ((1 << CFG_W) - 1);
		pool_writes++;
	endtask

	// mostly alloc/free of live blocks, plus refused requests, stray frees, re-inits and nops
	task automatic draw_word(output cmd_t w);
		int r, idx, off, sz;
		r = $urandom_range(99);
		w.request_bytes = 17'($urandom_range(0, 65536));
		w.block_offset = 16'($urandom);
		if (r < 45) begin
			w.func = FUNC_ALLOC;
			case ($urandom_range(9))
				7: sz = $urandom_range(65, 2048);
				8: sz = $urandom_range(0, 65536);
				9: begin
					sz = arena_end - 2 * WORD_BYTES - $urandom_range(0, 16);
					if (sz < 0) sz = 0;
				end
				default: sz = $urandom_range(1, 64);
			endcase
			w.request_bytes = 17'(sz);
		end else if (r < 80 && live_blocks.size() != 0) begin
			w.func = FUNC_FREE;
			idx = $urandom_range(live_blocks.size() - 1);
			off = live_blocks[idx];
			live_blocks.delete(idx);
			if ($urandom_range(7) == 0) off += $urandom_range(1, WORD_BYTES - 1);
			w.block_offset = 16'(off);
		end else if (r < 90) begin
			w.func = FUNC_FREE;
			off = int'(w.block_offset);
			// stray frees only touch header words that hold a defined value
			if (off >= 2 * WORD_BYTES && !tag_set[(off - WORD_BYTES) / WORD_BYTES])
				off = $urandom_range(0, 2 * WORD_BYTES - 1);
			w.block_offset = 16'(off);
		end else if (r < 95) begin
			w.func = FUNC_INIT;
			live_blocks.delete();
		end else if (r < 97) begin
			w.func = FUNC_ALLOC;
			w.request_bytes = '0;
		end else begin
			w.func = FUNC_NOP;
		end
	endtask

	function automatic int draw_pool_size(int seg);
		case (seg)
			0: return 256;
			1: return 65536;
			2: return 40;
			3: return 4096;
			4: return 1024;
			default: return $urandom_range(16, 65536);
		endcase
	endfunction

	always @(posedge clk) begin : check_words
		rsp_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result word: status %0d offset %0d",
						result.status, result.payload_offset);
			end else begin
				want = expected_words.pop_front();
				if (result.status !== want.status
						|| result.payload_offset !== want.payload_offset) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: want status %0d offset %0d, got %0d %0d",
							want.status, want.payload_offset,
							result.status, result.payload_offset);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("first_fit_block_allocator regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int ph, seg;
		cmd_t w;
		rsp_t none;
		none = '0;

		// directed part; pool_bytes holds its reset value of 65536 at first
		add_row(ROW_CMD, FUNC_ALLOC, 100, 0, 1, STAT_NOT_READY, 0);
		add_row(ROW_CMD, FUNC_FREE, 0, 0, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_NOP, 131071, 65535, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_INIT, 0, 0, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 0, 0, 1, STAT_NO_FIT, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 65536, 0, 1, STAT_TOO_BIG, 0);
		// splits off a one-word free block at the very top of the pool
		add_row(ROW_CMD, FUNC_ALLOC, 65504, 0, 1, STAT_OK, 16);
		add_row(ROW_CMD, FUNC_FREE, 0, 65535, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 1, 0, 1, STAT_NO_FIT, 0);
		add_row(ROW_CMD, FUNC_FREE, 0, 65535, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_FREE, 0, 16, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 1, 0, 1, STAT_OK, 16);
		add_row(ROW_CMD, FUNC_ALLOC, 8, 0, 1, STAT_OK, 32);
		add_row(ROW_CMD, FUNC_ALLOC, 16, 0, 0, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_FREE, 0, 17, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_FREE, 0, 32, 1, STAT_OK, 0);
		// two adjacent free blocks get merged on the way
		add_row(ROW_CMD, FUNC_ALLOC, 20, 0, 0, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_FREE, 0, 15, 1, STAT_OK, 0);
		add_row(ROW_CFG, FUNC_INIT, 8, 0, 0, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_INIT, 0, 0, 1, STAT_NOT_READY, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 1, 0, 1, STAT_NOT_READY, 0);
		add_row(ROW_CFG, FUNC_INIT, 16, 0, 0, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_INIT, 0, 0, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 1, 0, 1, STAT_TOO_BIG, 0);
		add_row(ROW_CFG, FUNC_INIT, 24, 0, 0, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_INIT, 0, 0, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 8, 0, 1, STAT_OK, 16);
		add_row(ROW_CFG, FUNC_INIT, 0, 0, 0, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_INIT, 0, 0, 1, STAT_NOT_READY, 0);
		add_row(ROW_CFG, FUNC_INIT, 65535, 0, 0, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_INIT, 0, 0, 1, STAT_OK, 0);
		add_row(ROW_CMD, FUNC_ALLOC, 65512, 0, 1, STAT_OK, 16);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 11;
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG)
				write_pool(directed_plan[i].pool_value);
			else
				send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
		end

		for (ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 11 : (ph == 1) ? 85 : 0;
			for (seg = 0; seg < 2; seg++) begin
				write_pool(draw_pool_size(2 * ph + seg));
				live_blocks.delete();
				w = '0;
				w.func = FUNC_INIT;
				send_word(w, 1'b0, none);
				repeat (SEGMENT_WORDS) begin
					draw_word(w);
					send_word(w, 1'b0, none);
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d command words (%0d placed, %0d refused, %0d frees), %0d pools",
			words_sent, allocs_placed, allocs_refused, frees_sent, pool_writes);
		$display("%0d result words checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("first_fit_block_allocator regression: pass");
		end else begin
			$display("first_fit_block_allocator regression: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_word_div.sv
rtl/first_fit_block_allocator.sv
test/first_fit_block_allocator_test.sv
